[hdl/dfq_pkg.sv]
// Package for the deduplicating first-in first-out key queue.
// Holds the sequencer state type and the operation codes; depends on nothing.
package dfq_pkg;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP
	} state_t;

endpackage

[hdl/dedup_fifo_queue_unit.sv]
// Top level of the deduplicating first-in first-out key queue.
// Depends on dfq_pkg and dfq_ram.
//
// A word is accepted at a rising edge where start is high and busy is low.
// operation selects a push of key (low KEY_BITS bits kept) or a pop of the
// oldest key. Every word yields exactly one result, shown on accepted,
// popped_key and entry_count for the single cycle in which done is high.
// The receiver cannot stall, so results are never held back.
//
// The keys live in a circular buffer in one RAM with a registered read.
// A push walks every queued entry through one shared equality comparator,
// one RAM read per cycle; the longest scan is over QUEUE_DEPTH - 1 entries
// (63 by default). A push to a full queue is refused without a scan. A pop
// makes one RAM read of the head key, and a pop of an empty queue is answered
// without a read. busy is high while a word is at work; done and the next
// accept may fall in the same cycle.
//
// Reset empties the queue at once; the RAM contents are left as they are,
// since only entries between the head and tail pointers are ever read.
module dedup_fifo_queue_unit #(
	parameter int QUEUE_DEPTH = 64,
	parameter int KEY_BITS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [63:0] key,
	output logic        done,
	output logic        accepted,
	output logic [63:0] popped_key,
	output logic [6:0]  entry_count
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	dfq_pkg::state_t state_q, state_nxt;

	logic [CW-1:0]       count_q, cnt_nxt;
	logic [AW-1:0]       head_q, tail_q, scan_addr_q;
	logic [CW-1:0]       issue_left_q;
	logic                pending_s1, hit_q;
	logic [KEY_BITS-1:0] key_q;
	logic                done_q, accepted_q;
	logic [63:0]         popped_key_q;
	logic [6:0]          entry_count_q;

	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr;
	logic [KEY_BITS-1:0] rd_data;
	logic                match_now, hit_now;
	logic                res_load, res_accepted;
	logic [63:0]         res_popped;
	logic                head_adv, tail_adv;
	logic                in_accept, queue_full;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	assign busy       = (state_q != dfq_pkg::ST_IDLE);
	assign in_accept  = start && !busy;
	assign queue_full = (count_q == FULL_CNT);
	assign match_now  = pending_s1 && (rd_data == key_q);
	assign hit_now    = hit_q || match_now;

	dfq_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_q),
		.wr_data(key_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dfq_pkg::ST_IDLE: begin
				if (start) begin
					if (operation == dfq_pkg::OP_POP) begin
						if (count_q != '0) begin
							state_nxt = dfq_pkg::ST_POP;
						end
					end else if (!queue_full) begin
						state_nxt = dfq_pkg::ST_SCAN;
					end
				end
			end
			dfq_pkg::ST_SCAN: begin
				if (issue_left_q == '0) begin
					state_nxt = dfq_pkg::ST_IDLE;
				end
			end
			dfq_pkg::ST_POP: begin
				state_nxt = dfq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = dfq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_en        = 1'b0;
		rd_addr      = head_q;
		wr_en        = 1'b0;
		res_load     = 1'b0;
		res_accepted = 1'b0;
		res_popped   = '0;
		cnt_nxt      = count_q;
		head_adv     = 1'b0;
		tail_adv     = 1'b0;
		unique case (state_q)
			dfq_pkg::ST_IDLE: begin
				if (start) begin
					if (operation == dfq_pkg::OP_POP) begin
						if (count_q != '0) begin
							rd_en = 1'b1;
						end else begin
							res_load = 1'b1;
						end
					end else if (queue_full) begin
						res_load = 1'b1;
					end
				end
			end
			dfq_pkg::ST_SCAN: begin
				if (issue_left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = scan_addr_q;
				end else begin
					res_load = 1'b1;
					if (!hit_now) begin
						wr_en        = 1'b1;
						tail_adv     = 1'b1;
						cnt_nxt      = count_q + 1'b1;
						res_accepted = 1'b1;
					end
				end
			end
			dfq_pkg::ST_POP: begin
				res_load     = 1'b1;
				res_accepted = 1'b1;
				res_popped   = 64'(rd_data);
				head_adv     = 1'b1;
				cnt_nxt      = count_q - 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dfq_pkg::ST_IDLE;
			count_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			scan_addr_q  <= '0;
			issue_left_q <= '0;
			pending_s1   <= 1'b0;
			hit_q        <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			count_q    <= cnt_nxt;
			done_q     <= res_load;
			pending_s1 <= (state_q == dfq_pkg::ST_SCAN) && rd_en;
			if (head_adv) begin
				head_q <= next_ptr(head_q);
			end
			if (tail_adv) begin
				tail_q <= next_ptr(tail_q);
			end
			if (in_accept) begin
				scan_addr_q  <= head_q;
				issue_left_q <= count_q;
				hit_q        <= 1'b0;
			end else if (state_q == dfq_pkg::ST_SCAN) begin
				hit_q <= hit_now;
				if (rd_en) begin
					scan_addr_q  <= next_ptr(scan_addr_q);
					issue_left_q <= issue_left_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			key_q <= key[KEY_BITS-1:0];
		end
		if (res_load) begin
			accepted_q    <= res_accepted;
			popped_key_q  <= res_popped;
			entry_count_q <= 7'(cnt_nxt);
		end
	end

	assign done        = done_q;
	assign accepted    = accepted_q;
	assign popped_key  = popped_key_q;
	assign entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("Queue count exceeds its depth.");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!queue_full && state_q == dfq_pkg::ST_SCAN))
		else $error("Key written outside a scan or into a full queue.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == dfq_pkg::ST_IDLE))
		else $error("Result shown while a word is still at work.");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !accepted_q) |-> (popped_key_q == '0))
		else $error("Refused word returned a nonzero key.");

	a_pop_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfq_pkg::ST_POP) |-> $past(rd_en && state_q == dfq_pkg::ST_IDLE))
		else $error("Pop result taken without a head read.");

endmodule

[hdl/dfq_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the queue's key storage; depends on nothing.
module dfq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[tb/dedup_fifo_queue_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench for the deduplicating first-in first-out key queue.
// Depends on dfq_pkg and dedup_fifo_queue_unit; predicts every result with its own key queue.
module dedup_fifo_queue_unit_tb;

	localparam int          QUEUE_DEPTH = 64;
	localparam int          KEY_BITS    = 64;
	localparam logic [63:0] KEY_MASK    = {64{1'b1}} >> (64 - KEY_BITS);
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          DRAIN_WAIT  = 80;

	typedef struct packed {
		logic        accepted;
		logic [63:0] popped_key;
		logic [6:0]  entry_count;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        operation = dfq_pkg::OP_PUSH;
	logic [63:0] key = '0;
	logic        done;
	logic        accepted;
	logic [63:0] popped_key;
	logic [6:0]  entry_count;

	logic [63:0]   held_keys[$];
	queue_result_t expected_results[$];

	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int checked_count = 0;
	int push_count = 0;
	int push_refused = 0;
	int pop_count = 0;
	int pop_empty = 0;
	int full_reached = 0;

	dedup_fifo_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.KEY_BITS(KEY_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.key(key),
		.done(done),
		.accepted(accepted),
		.popped_key(popped_key),
		.entry_count(entry_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dedup_fifo_queue_unit: mismatch");
			$finish;
		end
	end

	function automatic queue_result_t apply_queue_op(input logic op, input logic [63:0] raw_key);
		queue_result_t r;
		logic [63:0]   k;
		bit            present;
		k = raw_key & KEY_MASK;
		r = '0;
		present = 1'b0;
		if (op == dfq_pkg::OP_PUSH) begin
			push_count++;
			foreach (held_keys[i]) begin
				if (held_keys[i] == k) begin
					present = 1'b1;
				end
			end
			if (!present && held_keys.size() < QUEUE_DEPTH) begin
				held_keys.push_back(k);
				r.accepted = 1'b1;
				if (held_keys.size() == QUEUE_DEPTH) begin
					full_reached++;
				end
			end else begin
				push_refused++;
			end
		end else begin
			pop_count++;
			if (held_keys.size() > 0) begin
				r.popped_key = held_keys.pop_front();
				r.accepted = 1'b1;
			end else begin
				pop_empty++;
			end
		end
		r.entry_count = 7'(held_keys.size());
		return r;
	endfunction

	function automatic logic [63:0] fresh_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] queued_key();
		return held_keys[$urandom_range(0, held_keys.size() - 1)];
	endfunction

	// Leaves start high so that a following word goes out without a gap.
	task automatic send_word(input logic op, input logic [63:0] k);
		start <= 1'b1;
		operation <= op;
		key <= k;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		expected_results.push_back(apply_queue_op(op, k));
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			operation <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 9)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			                                        : $urandom_range(0, 8);
		end
	endtask

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no word outstanding: accepted %0b key %h count %0d",
				       accepted, popped_key, entry_count);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				if (accepted !== want.accepted) begin
					$error("accepted: expected %0b, got %0b", want.accepted, accepted);
					fail_count++;
				end
				if (popped_key !== want.popped_key) begin
					$error("popped_key: expected %h, got %h", want.popped_key, popped_key);
					fail_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
					fail_count++;
				end
			end
		end
	end

	task automatic test_pop_empty();
		send_word(dfq_pkg::OP_POP, {64{1'b1}});
		send_word(dfq_pkg::OP_POP, 64'd0);
	endtask

	task automatic test_key_extremes();
		send_word(dfq_pkg::OP_PUSH, 64'd0);
		send_word(dfq_pkg::OP_PUSH, {64{1'b1}});
		send_word(dfq_pkg::OP_PUSH, {32{2'b10}});
		send_word(dfq_pkg::OP_PUSH, {32{2'b01}});
		send_word(dfq_pkg::OP_PUSH, 64'd0);
		send_word(dfq_pkg::OP_PUSH, {64{1'b1}});
		send_word(dfq_pkg::OP_POP, {32{2'b10}});
		send_word(dfq_pkg::OP_PUSH, 64'd0);
		send_word(dfq_pkg::OP_PUSH, 64'h8000_0000_0000_0001);
		repeat (5) send_word(dfq_pkg::OP_POP, 64'd0);
		send_word(dfq_pkg::OP_POP, {64{1'b1}});
	endtask

	task automatic test_fill_and_drain(input int rounds);
		repeat (rounds) begin
			while (held_keys.size() < QUEUE_DEPTH) begin
				if (held_keys.size() > 0 && $urandom_range(0, 7) == 0) begin
					send_word(dfq_pkg::OP_PUSH, queued_key());
				end else begin
					send_word(dfq_pkg::OP_PUSH, fresh_key());
				end
				pace();
			end
			send_word(dfq_pkg::OP_PUSH, queued_key());
			pace();
			send_word(dfq_pkg::OP_PUSH, fresh_key());
			pace();
			while (held_keys.size() > 0) begin
				send_word(dfq_pkg::OP_POP, fresh_key());
				pace();
			end
			send_word(dfq_pkg::OP_POP, fresh_key());
			pace();
		end
	endtask

	task automatic test_random_mix(input int chunks, input int per_chunk);
		int push_pct;
		repeat (chunks) begin
			push_pct = $urandom_range(30, 80);
			repeat (per_chunk) begin
				if ($urandom_range(1, 100) <= push_pct) begin
					if (held_keys.size() > 0 && $urandom_range(0, 3) == 0) begin
						send_word(dfq_pkg::OP_PUSH, queued_key());
					end else begin
						send_word(dfq_pkg::OP_PUSH, fresh_key());
					end
				end else begin
					send_word(dfq_pkg::OP_POP, fresh_key());
				end
				pace();
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pop_empty();
		test_key_extremes();
		test_fill_and_drain(3);
		test_random_mix(7, 100);
		start <= 1'b0;
		while (expected_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_results.size() > 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		$display("Sent %0d pushes (%0d refused) and %0d pops (%0d on an empty queue).",
		         push_count, push_refused, pop_count, pop_empty);
		$display("The queue filled up %0d times; %0d results were checked.",
		         full_reached, checked_count);
		if (fail_count == 0) begin
			$display("dedup_fifo_queue_unit: match");
		end else begin
			$display("dedup_fifo_queue_unit: mismatch");
		end
		$finish;
	end

endmodule
